### hdl/phd_pkg.sv
// Shared types, constants and filter weights for the heartbeat detector.
package phd_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned ACC_W     = 31;
  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned WEIGHT_W  = 13;
  localparam int unsigned PROD_W    = 30;
  localparam int unsigned Z_W       = 32;
  localparam int unsigned STEP_W    = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SWING = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SWING = 8'd1;

  // Configuration reset values
  localparam logic [SAMPLE_W-1:0] MIN_SWING_RST = 16'd20;
  localparam logic [SAMPLE_W-1:0] MAX_SWING_RST = 16'd1000;

  // Filter schedule: one tap pair per step, center tap on the last step
  localparam logic [STEP_W-1:0] MID_STEP = 4'd11;
  localparam logic [5:0]        FIR_SPAN = 6'd22;
  localparam logic [STEP_W-1:0] RUN_LAST = 4'd13;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } phd_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic              start;
    logic              issue;
    logic [STEP_W-1:0] step;
    logic              finish;
  } phd_cmd_t;

  // Q15 weight for a tap pair (center tap on the last tap step)
  function automatic logic [WEIGHT_W-1:0] phd_weight(input logic [STEP_W-1:0] step);
    logic [WEIGHT_W-1:0] w;
    case (step)
      4'd0:    w = 13'd172;
      4'd1:    w = 13'd321;
      4'd2:    w = 13'd579;
      4'd3:    w = 13'd927;
      4'd4:    w = 13'd1360;
      4'd5:    w = 13'd1858;
      4'd6:    w = 13'd2390;
      4'd7:    w = 13'd2916;
      4'd8:    w = 13'd3391;
      4'd9:    w = 13'd3768;
      4'd10:   w = 13'd4012;
      4'd11:   w = 13'd4096;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

### hdl/phd_in_if.sv
// Sample input channel.
interface phd_in_if;
  logic                           valid;
  logic                           ready;
  logic [phd_pkg::SAMPLE_W-1:0]   sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

### hdl/phd_out_if.sv
// Result output channel.
interface phd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  beat_flag;
  logic signed [phd_pkg::SAMPLE_W-1:0]   ac_value;
  logic [phd_pkg::SAMPLE_W-1:0]          dc_estimate;

  modport source (output valid, output beat_flag, output ac_value,
                  output dc_estimate, input ready);
  modport sink   (input valid, input beat_flag, input ac_value,
                  input dc_estimate, output ready);
endinterface

### hdl/phd_cfg_if.sv
// Configuration write channel.
interface phd_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [phd_pkg::CFG_IDX_W-1:0]   index;
  logic [phd_pkg::SAMPLE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/phd_ctrl.sv
// Sequencer for the heartbeat detector: handshakes and filter step schedule.
module phd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 out_ready,
  output logic                 out_valid,
  output phd_pkg::phd_cmd_t    cmd
);

  phd_pkg::phd_state_t              state_r, state_nxt;
  logic [phd_pkg::STEP_W-1:0]       cnt_r, cnt_nxt;
  logic                             out_valid_r, out_valid_nxt;

  // State, step counter and output valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= phd_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    cmd        = '0;
    cmd.step   = cnt_r;
    in_ready   = 1'b0;
    case (state_r)
      phd_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
        cnt_nxt   = '0;
        if (in_valid) begin
          state_nxt = phd_pkg::ST_RUN;
        end
      end
      phd_pkg::ST_RUN: begin
        // issue ring reads for each tap pair, then let the MAC pipe drain
        cmd.issue = (cnt_r <= phd_pkg::MID_STEP);
        cnt_nxt   = cnt_r + 4'd1;
        if (cnt_r == phd_pkg::RUN_LAST) begin
          state_nxt = phd_pkg::ST_DONE;
        end
      end
      phd_pkg::ST_DONE: begin
        // hold until the output register is free
        cmd.finish = !out_valid_r || out_ready;
        if (cmd.finish) begin
          state_nxt = phd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = phd_pkg::ST_IDLE;
      end
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### hdl/phd_datapath.sv
// DC removal, ring memory, tap-pair MAC and zero-crossing beat logic.
module phd_datapath #(
  parameter int unsigned RING_DEPTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  phd_pkg::phd_cmd_t                    cmd,
  input  logic [phd_pkg::SAMPLE_W-1:0]         sample_in,
  input  logic                                 cfg_we,
  input  logic [phd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [phd_pkg::SAMPLE_W-1:0]         cfg_data,
  output logic                                 beat_flag,
  output logic signed [phd_pkg::SAMPLE_W-1:0] ac_value,
  output logic [phd_pkg::SAMPLE_W-1:0]         dc_estimate
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam logic [AW:0] DEPTH_EXT = (AW+1)'(RING_DEPTH);
  localparam logic [AW-1:0] POS_LAST = AW'(RING_DEPTH - 1);

  // Configuration
  logic [15:0] min_swing_r, max_swing_r;

  // DC estimator and ring
  logic [phd_pkg::ACC_W-1:0] acc_r;
  logic [AW-1:0]             pos_r;
  logic [15:0]               ring_mem [RING_DEPTH];
  logic [RING_DEPTH-1:0]     vld_r;

  // MAC pipeline
  logic                              s1_vld_r, s2_vld_r;
  logic [phd_pkg::STEP_W-1:0]        s1_step_r;
  logic [15:0]                       rd_a_r, rd_b_r;
  logic signed [phd_pkg::PROD_W-1:0] prod_r;
  logic signed [phd_pkg::Z_W-1:0]    z_r;

  // Tracking state
  logic signed [15:0] cur_r, peak_r, trough_r;
  logic               rph_r, fph_r;

  // Output payload
  logic               beat_r;
  logic signed [15:0] ac_out_r;
  logic [15:0]        dc_out_r;

  // ---- DC estimator ----
  logic signed [32:0]         dc_diff, dc_step, dc_sum;
  logic [phd_pkg::ACC_W-1:0]  acc_nxt;
  logic [15:0]                dc_new, ac_new;

  always_comb begin
    dc_diff = $signed({2'b00, sample_in, 15'd0}) - $signed({2'b00, acc_r});
    dc_step = dc_diff >>> 4;
    dc_sum  = $signed({2'b00, acc_r}) + dc_step;
    acc_nxt = dc_sum[30:0];
    dc_new  = acc_nxt[30:15];
    ac_new  = sample_in - dc_new;
  end

  // ---- Ring read addresses (modulo the depth) ----
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] pos,
                                               input logic [5:0] back);
    logic [AW:0] p, b;
    p = {1'b0, pos};
    b = (AW+1)'(back);
    if (p >= b) begin
      return AW'(p - b);
    end
    return AW'(p + DEPTH_EXT - b);
  endfunction

  logic [AW-1:0] addr_a, addr_b;
  logic [5:0]    back_a, back_b;

  always_comb begin
    back_a = {2'b00, cmd.step};
    back_b = phd_pkg::FIR_SPAN - back_a;
    addr_a = ring_addr(pos_r, back_a);
    addr_b = ring_addr(pos_r, back_b);
  end

  // Configuration registers; other indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_swing_r <= phd_pkg::MIN_SWING_RST;
      max_swing_r <= phd_pkg::MAX_SWING_RST;
    end else if (cfg_we) begin
      if (cfg_index == phd_pkg::REG_MIN_SWING) begin
        min_swing_r <= cfg_data;
      end
      if (cfg_index == phd_pkg::REG_MAX_SWING) begin
        max_swing_r <= cfg_data;
      end
    end
  end

  // Ring memory: write on start, two registered reads per step
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ring_mem[pos_r] <= ac_new;
    end
    rd_a_r <= vld_r[addr_a] ? ring_mem[addr_a] : 16'd0;
    rd_b_r <= vld_r[addr_b] ? ring_mem[addr_b] : 16'd0;
  end

  // Entry valid bits stand in for the zeroed ring after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.start) begin
      vld_r[pos_r] <= 1'b1;
    end
  end

  // ---- Tap-pair multiply and accumulate ----
  logic signed [15:0] pair;
  logic signed [13:0] weight_s;

  always_comb begin
    if (s1_step_r == phd_pkg::MID_STEP) begin
      pair = $signed(rd_a_r);
    end else begin
      pair = $signed(rd_a_r + rd_b_r);
    end
    weight_s = $signed({1'b0, phd_pkg::phd_weight(s1_step_r)});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= cmd.issue;
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_step_r <= cmd.step;
    prod_r    <= weight_s * pair;
    if (cmd.start) begin
      z_r <= '0;
    end else if (s2_vld_r) begin
      z_r <= z_r + phd_pkg::Z_W'(prod_r);
    end
  end

  // ---- Zero-crossing tracking ----
  logic signed [15:0] cur, peak_n, trough_n;
  logic               rise, fall, rph_n, fph_n, beat_n;
  logic signed [16:0] swing;
  logic signed [17:0] swing_x, min_x, max_x;

  always_comb begin
    cur      = z_r[30:15];
    rise     = (cur_r < 0) && (cur >= 0);
    fall     = (cur_r > 0) && (cur <= 0);
    swing    = {peak_r[15], peak_r} - {trough_r[15], trough_r};
    swing_x  = {swing[16], swing};
    min_x    = $signed({2'b00, min_swing_r});
    max_x    = $signed({2'b00, max_swing_r});
    beat_n   = rise && (swing_x > min_x) && (swing_x < max_x);
    rph_n    = rise ? 1'b1 : (fall ? 1'b0 : rph_r);
    fph_n    = rise ? 1'b0 : (fall ? 1'b1 : fph_r);
    peak_n   = rise ? 16'sd0 : peak_r;
    trough_n = fall ? 16'sd0 : trough_r;
    if (rph_n && (cur > cur_r)) begin
      peak_n = cur;
    end
    if (fph_n && (cur < cur_r)) begin
      trough_n = cur;
    end
  end

  // Advance estimator, ring position and tracking state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      pos_r    <= '0;
      cur_r    <= '0;
      peak_r   <= '0;
      trough_r <= '0;
      rph_r    <= 1'b0;
      fph_r    <= 1'b0;
    end else begin
      if (cmd.start) begin
        acc_r <= acc_nxt;
      end
      if (cmd.finish) begin
        pos_r    <= (pos_r == POS_LAST) ? '0 : pos_r + 1'b1;
        cur_r    <= cur;
        peak_r   <= peak_n;
        trough_r <= trough_n;
        rph_r    <= rph_n;
        fph_r    <= fph_n;
      end
    end
  end

  // Output payload register
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      beat_r   <= beat_n;
      ac_out_r <= cur;
      dc_out_r <= acc_r[30:15];
    end
  end

  assign beat_flag   = beat_r;
  assign ac_value    = ac_out_r;
  assign dc_estimate = dc_out_r;

endmodule

### hdl/ppg_heartbeat_detector.sv
// Heartbeat detector top level: channel handshakes, controller and datapath.
// Each 16-bit PPG sample has a leaky DC estimate removed, enters a ring of
// RING_DEPTH entries, and is low-pass filtered by a symmetric 23-tap FIR;
// rising zero crossings of the filtered signal flag a beat when the
// peak-to-trough swing lies strictly between beat_min_swing (register 0) and
// beat_max_swing (register 1). One result item follows every input item.
// An item accepted in the idle state runs twelve filter steps,
// one tap pair per cycle read through the two read ports of the ring memory
// into one shared multiplier, then drains the MAC pipeline and loads the result.
// A new item is accepted only once the last one has loaded its result. The
// result register lets the next item start while a result waits. The ring
// is cleared by per-entry valid bits, so no clearing pass follows reset.
// Configuration writes are always ready and should be issued while idle.
module ppg_heartbeat_detector #(
  parameter int unsigned RING_DEPTH = 32
) (
  input logic       clk,
  input logic       rst_n,
  phd_in_if.sink    in_ch,
  phd_out_if.source out_ch,
  phd_cfg_if.sink   cfg_ch
);

  phd_pkg::phd_cmd_t cmd;

  assign cfg_ch.ready = 1'b1;

  // Sequencer
  phd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd)
  );

  // Filter and beat datapath
  phd_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sample_in     (in_ch.sample_in),
    .cfg_we        (cfg_ch.valid),
    .cfg_index     (cfg_ch.index),
    .cfg_data      (cfg_ch.data),
    .beat_flag     (out_ch.beat_flag),
    .ac_value      (out_ch.ac_value),
    .dc_estimate   (out_ch.dc_estimate)
  );

endmodule

### hdl/phd_checker.sv
// Port-level checks for the heartbeat detector and their bind.
module phd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        beat_flag,
  input logic [15:0] ac_value,
  input logic        cfg_ready
);

  // One item at a time: no acceptance right after one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // A beat is only flagged on a nonnegative filtered value
  a_beat_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && beat_flag) |-> !ac_value[15])
    else $error("beat on negative ac value");

  // A waiting result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before taken");

  // Reset leaves no result pending and the config port open
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && cfg_ready))
    else $error("state after reset wrong");

endmodule

bind ppg_heartbeat_detector phd_checker u_phd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .beat_flag     (out_ch.beat_flag),
  .ac_value      (out_ch.ac_value),
  .cfg_ready     (cfg_ch.ready)
);

### sim/tb.sv
// Self-checking testbench for the PPG heartbeat detector: random waveforms, scored per item.
`timescale 1ns / 100ps

module tb;

  localparam int RING_LEN       = 32;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int SETTLE_CYCLES  = 40;

  // Register indexes the block does not implement; writes to them are dropped
  localparam logic [phd_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 8'd2;
  localparam logic [phd_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 8'd255;

  typedef struct packed {
    logic                                beat;
    logic signed [phd_pkg::SAMPLE_W-1:0] ac;
    logic [phd_pkg::SAMPLE_W-1:0]        dc;
  } beat_result_t;

  logic clk;
  logic rst_n;

  phd_in_if  in_ch ();
  phd_out_if out_ch ();
  phd_cfg_if cfg_ch ();

  ppg_heartbeat_detector dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Stimulus and scoreboard storage
  logic [phd_pkg::SAMPLE_W-1:0] sample_q [$];
  beat_result_t                 predicted_beats [$];

  int send_idle_pct = 34;
  int recv_idle_pct = 34;
  int hold_req      = 0;
  int hold_done     = 0;
  int hold_left     = 0;
  int queued        = 0;

  logic in_taken;
  int   stall_cycles;
  int   errors       = 0;
  int   n_samples    = 0;
  int   n_results    = 0;
  int   n_beats      = 0;
  int   n_reg_writes = 0;
  int   n_phases     = 0;

  // Predictor state
  int                                  fir_w [12] = '{172, 321, 579, 927, 1360, 1858,
                                                      2390, 2916, 3391, 3768, 4012, 4096};
  logic [phd_pkg::SAMPLE_W-1:0]        min_swing;
  logic [phd_pkg::SAMPLE_W-1:0]        max_swing;
  logic [phd_pkg::ACC_W-1:0]           dc_acc;
  logic signed [phd_pkg::SAMPLE_W-1:0] hist [RING_LEN];
  int                                  pos;
  logic signed [phd_pkg::SAMPLE_W-1:0] cur_ac;
  logic signed [phd_pkg::SAMPLE_W-1:0] prev_ac;
  logic signed [phd_pkg::SAMPLE_W-1:0] peak;
  logic signed [phd_pkg::SAMPLE_W-1:0] trough;
  logic                                rising;
  logic                                falling;

  // Clock, plus known levels on every input from time zero
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.sample_in = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    forever #10 clk = ~clk;
  end

  task automatic clear_predictor();
    min_swing = phd_pkg::MIN_SWING_RST;
    max_swing = phd_pkg::MAX_SWING_RST;
    dc_acc = '0;
    for (int i = 0; i < RING_LEN; i++) hist[i] = '0;
    pos = 0;
    cur_ac = '0;
    prev_ac = '0;
    peak = '0;
    trough = '0;
    rising = 1'b0;
    falling = 1'b0;
  endtask

  function automatic logic signed [phd_pkg::SAMPLE_W-1:0] tap_at(input int back);
    return hist[(pos + RING_LEN - back) % RING_LEN];
  endfunction

  // Advance the predictor by one sample and return the result it should produce
  task automatic filter_sample(input logic [phd_pkg::SAMPLE_W-1:0] x,
                               output beat_result_t r);
    longint                              d;
    longint                              z;
    logic [phd_pkg::SAMPLE_W-1:0]        dc;
    logic signed [phd_pkg::SAMPLE_W-1:0] pair;
    int                                  swing;
    logic                                is_beat;
    is_beat = 1'b0;
    prev_ac = cur_ac;

    // Leaky DC tracker; arithmetic shift of a signed value floors
    d = (longint'(x) <<< 15) - longint'(dc_acc);
    dc_acc = phd_pkg::ACC_W'(longint'(dc_acc) + (d >>> 4));
    dc = dc_acc[phd_pkg::ACC_W-1:15];
    hist[pos] = x - dc;

    // Symmetric FIR, pair sums wrap to 16 bits
    z = longint'(fir_w[11]) * tap_at(11);
    for (int i = 0; i < 11; i++) begin
      pair = tap_at(i) + tap_at(22 - i);
      z += longint'(fir_w[i]) * pair;
    end
    pos = (pos + 1) % RING_LEN;
    cur_ac = phd_pkg::SAMPLE_W'(z >>> 15);

    // Zero-crossing swing tracking
    if (prev_ac < 0 && cur_ac >= 0) begin
      swing = int'(peak) - int'(trough);
      rising = 1'b1;
      falling = 1'b0;
      peak = '0;
      if (swing > int'(min_swing) && swing < int'(max_swing)) is_beat = 1'b1;
    end
    if (prev_ac > 0 && cur_ac <= 0) begin
      rising = 1'b0;
      falling = 1'b1;
      trough = '0;
    end
    if (rising && cur_ac > prev_ac) peak = cur_ac;
    if (falling && cur_ac < prev_ac) trough = cur_ac;

    r.beat = is_beat;
    r.ac = cur_ac;
    r.dc = dc;
  endtask

  // Sample driver: hold an item until taken, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (in_ch.valid && !in_taken) begin
      // keep the current item on the bus
    end else if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
      in_ch.valid <= 1'b1;
      in_ch.sample_in <= sample_q.pop_front();
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  // Result sink: random back-pressure plus requested long hold-offs
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_req != hold_done) begin
      hold_done <= hold_done + 1;
      hold_left <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predict on every accepted sample, check every accepted result
  always @(posedge clk) begin : monitor
    beat_result_t want;
    logic         moved;
    if (!rst_n) begin
      clear_predictor();
      in_taken <= 1'b0;
      stall_cycles <= 0;
    end else begin
      moved = 1'b0;
      in_taken <= in_ch.valid && in_ch.ready;

      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        n_reg_writes++;
        if (cfg_ch.index == phd_pkg::REG_MIN_SWING) min_swing = cfg_ch.data;
        else if (cfg_ch.index == phd_pkg::REG_MAX_SWING) max_swing = cfg_ch.data;
      end

      if (in_ch.valid && in_ch.ready) begin
        moved = 1'b1;
        n_samples++;
        filter_sample(in_ch.sample_in, want);
        predicted_beats.push_back(want);
      end

      if (out_ch.valid && out_ch.ready) begin
        moved = 1'b1;
        if (predicted_beats.size() == 0) begin
          errors++;
          $display("%0t: expected no result, actual beat=%0b ac=%0d dc=%0d", $time,
                   out_ch.beat_flag, out_ch.ac_value, out_ch.dc_estimate);
        end else begin
          want = predicted_beats.pop_front();
          n_results++;
          if (want.beat) n_beats++;
          if (out_ch.beat_flag !== want.beat || out_ch.ac_value !== want.ac ||
              out_ch.dc_estimate !== want.dc) begin
            errors++;
            $display("%0t: result %0d expected beat=%0b ac=%0d dc=%0d,",
                     $time, n_results, want.beat, want.ac, want.dc,
                     " actual beat=%0b ac=%0d dc=%0d",
                     out_ch.beat_flag, out_ch.ac_value, out_ch.dc_estimate);
          end
        end
      end

      stall_cycles <= moved ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic write_reg(input logic [phd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [phd_pkg::SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Block until every queued sample is taken and every result has come back
  task automatic wait_drained();
    do @(posedge clk);
    while (sample_q.size() != 0 || in_ch.valid || predicted_beats.size() != 0);
  endtask

  // Queue one stretch of samples: mostly noisy triangle pulses, some noise and flat runs
  task automatic queue_segment(input int room);
    int kind, len, base, amp, period, noise, h, t, v, tri_v, level;
    kind = $urandom_range(99);
    len = $urandom_range(40, 160);
    if (len > room) len = room;
    if (kind < 70) begin
      base = $urandom_range(65535);
      amp = ($urandom_range(9) == 0) ? $urandom_range(400, 12000) : $urandom_range(4, 400);
      period = $urandom_range(24, 90);
      noise = $urandom_range(amp / 4);
      h = period / 2;
      for (int k = 0; k < len; k++) begin
        t = k % period;
        v = (t < h) ? t : period - t;
        tri_v = (2 * amp * v) / h - amp;
        sample_q.push_back(phd_pkg::SAMPLE_W'(base + tri_v +
                                              int'($urandom_range(2 * noise)) - noise));
      end
      queued += len;
    end else if (kind < 85) begin
      for (int k = 0; k < len; k++) sample_q.push_back(phd_pkg::SAMPLE_W'($urandom));
      queued += len;
    end else begin
      case ($urandom_range(2))
        0:       level = 0;
        1:       level = 65535;
        default: level = $urandom_range(65535);
      endcase
      for (int k = 0; k < len; k++) sample_q.push_back(phd_pkg::SAMPLE_W'(level));
      queued += len;
    end
  endtask

  task automatic run_phase(input int n);
    int target;
    target = queued + n;
    while (queued < target) queue_segment(target - queued);
    wait_drained();
    n_phases++;
  endtask

  // Stimulus sequence
  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, single-bit patterns, full-scale swings
    sample_q = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000,
                 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'h0001, 16'hFFFE,
                 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000};
    queued = sample_q.size();
    wait_drained();

    // Reset thresholds
    run_phase(300);

    // Widest window, no idling on either side
    write_reg(phd_pkg::REG_MIN_SWING, 16'd0);
    write_reg(phd_pkg::REG_MAX_SWING, 16'hFFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(300);
    send_idle_pct = 34;
    recv_idle_pct = 34;

    // Inverted window; spare indexes must be ignored; sink stalls while samples pile up
    write_reg(phd_pkg::REG_MIN_SWING, 16'hFFFF);
    write_reg(phd_pkg::REG_MAX_SWING, 16'd0);
    write_reg(REG_SPARE_LO, 16'd5);
    write_reg(REG_SPARE_HI, 16'h1234);
    hold_req++;
    run_phase(250);

    // Equal thresholds: empty window
    write_reg(phd_pkg::REG_MIN_SWING, 16'd300);
    write_reg(phd_pkg::REG_MAX_SWING, 16'd300);
    run_phase(200);

    // Random window, with a full pause halfway through
    write_reg(phd_pkg::REG_MIN_SWING, phd_pkg::SAMPLE_W'($urandom_range(100)));
    write_reg(phd_pkg::REG_MAX_SWING, phd_pkg::SAMPLE_W'($urandom_range(200, 2000)));
    run_phase(150);
    run_phase(150);

    // Back to reset values
    write_reg(phd_pkg::REG_MIN_SWING, phd_pkg::MIN_SWING_RST);
    write_reg(phd_pkg::REG_MAX_SWING, phd_pkg::MAX_SWING_RST);
    write_reg(REG_SPARE_HI, phd_pkg::SAMPLE_W'($urandom));
    run_phase(300);

    // Both thresholds zero
    write_reg(phd_pkg::REG_MIN_SWING, 16'd0);
    write_reg(phd_pkg::REG_MAX_SWING, 16'd0);
    run_phase(150);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("tb: %0d samples in %0d threshold phases, %0d results checked, %0d beats",
             n_samples, n_phases, n_results, n_beats);
    $display("tb: %0d register writes, %0d mismatches", n_reg_writes, errors);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### ppg_heartbeat_detector.f
hdl/phd_pkg.sv
hdl/phd_in_if.sv
hdl/phd_out_if.sv
hdl/phd_cfg_if.sv
hdl/phd_ctrl.sv
hdl/phd_datapath.sv
hdl/ppg_heartbeat_detector.sv
hdl/phd_checker.sv
sim/tb.sv
